[rtl/iea_pkg.sv]
// ----------------------------------------------------------------------------
// iea_pkg
// Shared types and constants of the integer execute stage.
// ----------------------------------------------------------------------------
`default_nettype none

package iea_pkg;

    localparam int WORD_BITS = 32;
    localparam int IMM_BITS  = 16;
    localparam int KIND_BITS = 4;

    // opcodes
    typedef enum logic [KIND_BITS-1:0] {
        OP_NONE = 4'd0,
        OP_ADD  = 4'd1,
        OP_SUB  = 4'd2,
        OP_MUL  = 4'd3,
        OP_DIV  = 4'd4,
        OP_XOR  = 4'd5,
        OP_AND  = 4'd6,
        OP_OR   = 4'd7,
        OP_ADDI = 4'd8,
        OP_SUBI = 4'd9,
        OP_LD   = 4'd10,
        OP_ST   = 4'd11,
        OP_BEQZ = 4'd12,
        OP_BNEZ = 4'd13
    } t_op;

    // state carried by one cell of the chain
    typedef struct packed {
        logic                 vld;
        logic                 is_div;
        logic                 neg;
        logic                 dz;
        logic                 cond;
        logic [WORD_BITS-1:0] res;
        logic [WORD_BITS-1:0] rem;
        logic [WORD_BITS-1:0] quo;
        logic [WORD_BITS-1:0] dvs;
    } t_cell;

endpackage

`default_nettype wire

[rtl/iea_if.sv]
// ----------------------------------------------------------------------------
// iea_req_if / iea_rsp_if
// Valid/ready channels for instruction requests and execute results.
// ----------------------------------------------------------------------------
`default_nettype none

interface iea_req_if;
    logic                              valid;
    logic                              ready;
    logic [iea_pkg::KIND_BITS-1:0]     kind;
    logic                              bubble;
    logic [iea_pkg::WORD_BITS-1:0]     operand_a;
    logic [iea_pkg::WORD_BITS-1:0]     operand_b;
    logic [iea_pkg::IMM_BITS-1:0]      immediate;
    logic [iea_pkg::WORD_BITS-1:0]     program_counter;
    logic [iea_pkg::WORD_BITS-1:0]     prior_result;
    logic                              prior_cond;

    modport source (output valid, kind, bubble, operand_a, operand_b, immediate,
                    program_counter, prior_result, prior_cond, input ready);
    modport sink   (input valid, kind, bubble, operand_a, operand_b, immediate,
                    program_counter, prior_result, prior_cond, output ready);
endinterface

interface iea_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [iea_pkg::WORD_BITS-1:0]     alu_result;
    logic                              branch_taken;
    logic                              div_by_zero;

    modport source (output valid, alu_result, branch_taken, div_by_zero, input ready);
    modport sink   (input valid, alu_result, branch_taken, div_by_zero, output ready);
endinterface

`default_nettype wire

[rtl/iea_front.sv]
// ----------------------------------------------------------------------------
// iea_front
// Decode stage: computes every non-divide result and loads the divide cells.
// ----------------------------------------------------------------------------
`default_nettype none

module iea_front (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_en,
    input  wire                                i_vld,
    input  wire  [iea_pkg::KIND_BITS-1:0]      i_kind,
    input  wire                                i_bubble,
    input  wire  [iea_pkg::WORD_BITS-1:0]      i_a,
    input  wire  [iea_pkg::WORD_BITS-1:0]      i_b,
    input  wire  [iea_pkg::IMM_BITS-1:0]       i_imm,
    input  wire  [iea_pkg::WORD_BITS-1:0]      i_pc,
    input  wire  [iea_pkg::WORD_BITS-1:0]      i_prior_res,
    input  wire                                i_prior_cond,
    output iea_pkg::t_cell                     o_cell
);

    localparam int W = iea_pkg::WORD_BITS;

    iea_pkg::t_cell r_cell;
    iea_pkg::t_cell n_cell;
    logic [W-1:0]   w_imm;
    logic [W-1:0]   w_prod;
    logic           w_na;
    logic           w_nb;

    // sign-extended immediate and the one multiplier
    assign w_imm  = {{(W-iea_pkg::IMM_BITS){i_imm[iea_pkg::IMM_BITS-1]}}, i_imm};
    assign w_prod = i_a * i_b;
    assign w_na   = i_a[W-1];
    assign w_nb   = i_b[W-1];

    // opcode decode and result select
    always_comb begin
        n_cell        = '0;
        n_cell.vld    = i_vld;
        n_cell.res    = i_prior_res;
        n_cell.cond   = i_prior_cond;
        n_cell.neg    = w_na ^ w_nb;
        n_cell.quo    = w_na ? (W'(0) - i_a) : i_a;
        n_cell.dvs    = w_nb ? (W'(0) - i_b) : i_b;
        if (!i_bubble) begin
            case (iea_pkg::t_op'(i_kind))
                iea_pkg::OP_ADD:  n_cell.res = i_a + i_b;
                iea_pkg::OP_SUB:  n_cell.res = i_a - i_b;
                iea_pkg::OP_MUL:  n_cell.res = w_prod;
                iea_pkg::OP_DIV: begin
                    if (i_b == '0) begin
                        n_cell.dz = 1'b1;
                    end else begin
                        n_cell.is_div = 1'b1;
                    end
                end
                iea_pkg::OP_XOR:  n_cell.res = i_a ^ i_b;
                iea_pkg::OP_AND:  n_cell.res = i_a & i_b;
                iea_pkg::OP_OR:   n_cell.res = i_a | i_b;
                iea_pkg::OP_ADDI,
                iea_pkg::OP_LD,
                iea_pkg::OP_ST:   n_cell.res = i_a + w_imm;
                iea_pkg::OP_SUBI: n_cell.res = i_a - w_imm;
                iea_pkg::OP_BEQZ: begin
                    n_cell.res  = i_pc + {w_imm[W-3:0], 2'b00};
                    n_cell.cond = (i_a == '0);
                end
                iea_pkg::OP_BNEZ: begin
                    n_cell.res  = i_pc + {w_imm[W-3:0], 2'b00};
                    n_cell.cond = (i_a != '0);
                end
                default: n_cell.res = i_prior_res;
            endcase
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

`default_nettype wire

[rtl/iea_div_cell.sv]
// ----------------------------------------------------------------------------
// iea_div_cell
// One cell of the divide chain: retires one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module iea_div_cell (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_en,
    input  iea_pkg::t_cell     i_cell,
    output iea_pkg::t_cell     o_cell
);

    localparam int W = iea_pkg::WORD_BITS;

    iea_pkg::t_cell r_cell;
    iea_pkg::t_cell n_cell;
    logic [W:0]     w_sh;
    logic [W:0]     w_diff;
    logic           w_ge;

    // restoring step on the shifted partial remainder
    assign w_sh   = {i_cell.rem, i_cell.quo[W-1]};
    assign w_diff = w_sh - {1'b0, i_cell.dvs};
    assign w_ge   = !w_diff[W];

    always_comb begin
        n_cell     = i_cell;
        n_cell.rem = w_ge ? w_diff[W-1:0] : w_sh[W-1:0];
        n_cell.quo = {i_cell.quo[W-2:0], w_ge};
    end

    // cell register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

`default_nettype wire

[rtl/integer_execute_alu.sv]
// ----------------------------------------------------------------------------
// integer_execute_alu
// Execute stage of an in-order integer pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one instruction request per valid/ready handshake; o_rsp
//   returns exactly one result per request, in request order.
//   A request passes through a decode stage, one divide cell per quotient
//   bit, and an output register. Every request travels the full chain so
//   results stay in order.
//   Throughput is one request per cycle while o_rsp is not stalled; the chain
//   is fully pipelined and the multiplier sits alone in the decode stage.
//   When the receiver stalls with a result waiting, the whole chain holds
//   and i_req.ready drops; it rises again the cycle o_rsp is taken.
//   Reset clears every valid bit in the chain; no requests are in flight
//   afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_execute_alu (
    input  wire        i_clk,
    input  wire        i_rst_n,
    iea_req_if.sink    i_req,
    iea_rsp_if.source  o_rsp
);

    localparam int W = iea_pkg::WORD_BITS;

    iea_pkg::t_cell w_chain [W+1];
    iea_pkg::t_cell w_last;
    logic           w_adv;
    logic           r_out_vld;
    logic [W-1:0]   r_out_res;
    logic           r_out_cond;
    logic           r_out_dz;
    logic [W-1:0]   w_res;

    // chain advances when the output slot is free or being drained
    assign w_adv       = !r_out_vld || o_rsp.ready;
    assign i_req.ready = w_adv;

    // decode stage
    iea_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_adv),
        .i_vld        (i_req.valid),
        .i_kind       (i_req.kind),
        .i_bubble     (i_req.bubble),
        .i_a          (i_req.operand_a),
        .i_b          (i_req.operand_b),
        .i_imm        (i_req.immediate),
        .i_pc         (i_req.program_counter),
        .i_prior_res  (i_req.prior_result),
        .i_prior_cond (i_req.prior_cond),
        .o_cell       (w_chain[0])
    );

    // divide cells
    for (genvar g = 0; g < W; g++) begin : g_cell
        iea_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    assign w_last = w_chain[W];

    // quotient sign fix and final select
    assign w_res = !w_last.is_div ? w_last.res :
                   (w_last.neg ? (W'(0) - w_last.quo) : w_last.quo);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_last.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_res  <= w_res;
            r_out_cond <= w_last.cond;
            r_out_dz   <= w_last.dz;
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.alu_result   = r_out_res;
    assign o_rsp.branch_taken = r_out_cond;
    assign o_rsp.div_by_zero  = r_out_dz;

    // chain empty right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !r_out_vld)
        else $error("output valid after reset");

    // a zero divisor never enters the divide path
    a_dz_nodiv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.vld && w_last.dz |-> !w_last.is_div)
        else $error("divide by zero flagged on a divide");

    // a stalled result is not dropped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_rsp.ready |=> r_out_vld && $stable(r_out_res))
        else $error("stalled result lost");

endmodule

`default_nettype wire

[sim/integer_execute_alu_tb.sv]
// ----------------------------------------------------------------------------
// integer_execute_alu_tb
// Drives instruction requests through the execute stage under random idling
// on both channels and checks every result against an in-order prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// expected execute result for one request
typedef struct packed {
    logic [31:0] alu_result;
    logic        branch_taken;
    logic        div_by_zero;
} t_exe_result;

class exe_scoreboard;
    t_exe_result pending[$];
    int          errors = 0;

    // predict the result of one accepted request
    function void note_request(logic [3:0] kind, logic bubble, logic [31:0] a,
                               logic [31:0] b, logic [15:0] imm, logic [31:0] pc,
                               logic [31:0] prior_res, logic prior_cond);
        t_exe_result r;
        logic [31:0] imm_x;
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] q;
        imm_x = {{16{imm[15]}}, imm};
        r.alu_result   = prior_res;
        r.branch_taken = prior_cond;
        r.div_by_zero  = 1'b0;
        if (!bubble) begin
            case (kind)
                iea_pkg::OP_ADD: r.alu_result = a + b;
                iea_pkg::OP_SUB: r.alu_result = a - b;
                iea_pkg::OP_MUL: r.alu_result = a * b;
                iea_pkg::OP_DIV: begin
                    if (b == 32'd0) begin
                        r.div_by_zero = 1'b1;
                    end else begin
                        // magnitude divide then restore the sign
                        ua = a[31] ? -a : a;
                        ub = b[31] ? -b : b;
                        q  = ua / ub;
                        r.alu_result = (a[31] != b[31]) ? -q : q;
                    end
                end
                iea_pkg::OP_XOR: r.alu_result = a ^ b;
                iea_pkg::OP_AND: r.alu_result = a & b;
                iea_pkg::OP_OR:  r.alu_result = a | b;
                iea_pkg::OP_ADDI, iea_pkg::OP_LD, iea_pkg::OP_ST:
                    r.alu_result = a + imm_x;
                iea_pkg::OP_SUBI: r.alu_result = a - imm_x;
                iea_pkg::OP_BEQZ: begin
                    r.alu_result   = pc + (imm_x << 2);
                    r.branch_taken = (a == 32'd0);
                end
                iea_pkg::OP_BNEZ: begin
                    r.alu_result   = pc + (imm_x << 2);
                    r.branch_taken = (a != 32'd0);
                end
                default: ;
            endcase
        end
        pending.push_back(r);
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(logic [31:0] res, logic taken, logic dz);
        t_exe_result e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result res=%h taken=%b dz=%b", $time, res, taken, dz);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (res !== e.alu_result) begin
            $display("%0t: alu_result expected %h actual %h", $time, e.alu_result, res);
            errors++;
        end
        if (taken !== e.branch_taken) begin
            $display("%0t: branch_taken expected %b actual %b",
                     $time, e.branch_taken, taken);
            errors++;
        end
        if (dz !== e.div_by_zero) begin
            $display("%0t: div_by_zero expected %b actual %b", $time, e.div_by_zero, dz);
            errors++;
        end
    endfunction
endclass

module integer_execute_alu_tb;
    localparam int LATENCY   = 34;
    localparam int WDOG_LIMIT = 5000;

    // opcodes the stage does not know
    localparam logic [3:0] OP_RSVD_14 = 4'd14;
    localparam logic [3:0] OP_RSVD_15 = 4'd15;

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   wdog;

    iea_req_if req_if();
    iea_rsp_if rsp_if();

    exe_scoreboard sb;

    integer_execute_alu u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver side with random stalls, checks each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            sb.check_result(rsp_if.alu_result, rsp_if.branch_taken, rsp_if.div_by_zero);
        end
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || !i_rst_n) begin
            wdog <= 0;
        end else if (wdog >= WDOG_LIMIT) begin
            $display("[integer_execute_alu] ERROR");
            $finish;
        end else begin
            wdog <= wdog + 1;
        end
    end

    // send one request and wait until it is accepted
    task automatic send_request(logic [3:0] kind, logic bubble, logic [31:0] a,
                                logic [31:0] b, logic [15:0] imm, logic [31:0] pc,
                                logic [31:0] prior_res, logic prior_cond);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid           <= 1'b1;
        req_if.kind            <= kind;
        req_if.bubble          <= bubble;
        req_if.operand_a       <= a;
        req_if.operand_b       <= b;
        req_if.immediate       <= imm;
        req_if.program_counter <= pc;
        req_if.prior_result    <= prior_res;
        req_if.prior_cond      <= prior_cond;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(kind, bubble, a, b, imm, pc, prior_res, prior_cond);
    endtask

    // pick an operand that often lands on an edge value
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'd0;
            3: return 32'($urandom_range(15) - 8);
            default: return 32'($urandom);
        endcase
    endfunction

    // random request: mostly valid opcodes, some bubbles and unknown codes
    task automatic send_random();
        logic [3:0] kind;
        logic [31:0] b;
        kind = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                        : 4'($urandom_range(13) + 1);
        b = pick_operand();
        if (kind == iea_pkg::OP_DIV && $urandom_range(5) == 0) b = 32'd0;
        send_request(kind, ($urandom_range(11) == 0), pick_operand(), b,
                     16'($urandom), 32'($urandom), 32'($urandom),
                     1'($urandom_range(1)));
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        wdog = 0;
        send_idle_pct = 19;
        recv_idle_pct = 76;
        req_if.valid = 1'b0;
        req_if.kind = iea_pkg::OP_NONE;
        req_if.bubble = 1'b0;
        req_if.operand_a = '0;
        req_if.operand_b = '0;
        req_if.immediate = '0;
        req_if.program_counter = '0;
        req_if.prior_result = '0;
        req_if.prior_cond = 1'b0;
        rsp_if.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every opcode, edge values and special cases
        send_request(iea_pkg::OP_ADD, 1'b0, 32'h7FFF_FFFF, 32'd1, 16'h0, 32'h0,
                     32'h1234, 1'b1);
        send_request(iea_pkg::OP_SUB, 1'b0, 32'h8000_0000, 32'd1, 16'h0, 32'h0,
                     32'h0, 1'b0);
        send_request(iea_pkg::OP_MUL, 1'b0, 32'hFFFF_FFFF, 32'h8000_0000, 16'h0, 32'h0,
                     32'h0, 1'b0);
        send_request(iea_pkg::OP_DIV, 1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 16'h0, 32'h0,
                     32'h0, 1'b0);
        send_request(iea_pkg::OP_DIV, 1'b0, -32'sd7, 32'd2, 16'h0, 32'h0,
                     32'h0, 1'b0);
        send_request(iea_pkg::OP_DIV, 1'b0, 32'd7, -32'sd2, 16'h0, 32'h0,
                     32'h0, 1'b1);
        send_request(iea_pkg::OP_DIV, 1'b0, 32'd5, 32'd0, 16'h0, 32'h0,
                     32'hDEAD_BEEF, 1'b1);
        send_request(iea_pkg::OP_XOR, 1'b0, 32'hFFFF_FFFF, 32'h5555_5555, 16'h0, 32'h0,
                     32'h0, 1'b0);
        send_request(iea_pkg::OP_AND, 1'b0, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 16'h0, 32'h0,
                     32'h0, 1'b0);
        send_request(iea_pkg::OP_OR, 1'b0, 32'h0, 32'h8000_0001, 16'h0, 32'h0,
                     32'h0, 1'b0);
        send_request(iea_pkg::OP_ADDI, 1'b0, 32'h7FFF_FFFF, 32'h0, 16'h7FFF, 32'h0,
                     32'h0, 1'b0);
        send_request(iea_pkg::OP_SUBI, 1'b0, 32'h8000_0000, 32'h0, 16'h8000, 32'h0,
                     32'h0, 1'b0);
        send_request(iea_pkg::OP_LD, 1'b0, 32'h1000, 32'h0, 16'hFFFF, 32'h0,
                     32'h0, 1'b0);
        send_request(iea_pkg::OP_ST, 1'b0, 32'h0, 32'h0, 16'h8000, 32'h0,
                     32'h0, 1'b0);
        send_request(iea_pkg::OP_BEQZ, 1'b0, 32'h0, 32'h0, 16'h8000, 32'h0000_0010,
                     32'h0, 1'b0);
        send_request(iea_pkg::OP_BEQZ, 1'b0, 32'h1, 32'h0, 16'h7FFF, 32'hFFFF_FFFF,
                     32'h0, 1'b1);
        send_request(iea_pkg::OP_BNEZ, 1'b0, 32'h8000_0000, 32'h0, 16'h1, 32'hFFFF_FFFC,
                     32'h0, 1'b0);
        send_request(iea_pkg::OP_BNEZ, 1'b0, 32'h0, 32'h0, 16'hFFFF, 32'h0,
                     32'h0, 1'b1);
        send_request(iea_pkg::OP_ADD, 1'b1, 32'h1, 32'h1, 16'h1, 32'h0,
                     32'hFFFF_FFFF, 1'b1);
        send_request(iea_pkg::OP_DIV, 1'b1, 32'h1, 32'h0, 16'h1, 32'h0,
                     32'h8000_0000, 1'b0);
        send_request(iea_pkg::OP_NONE, 1'b0, 32'h1, 32'h1, 16'h1, 32'h0,
                     32'h7FFF_FFFF, 1'b1);
        send_request(OP_RSVD_14, 1'b0, 32'h1, 32'h1, 16'h1, 32'h0,
                     32'h0, 1'b0);
        send_request(OP_RSVD_15, 1'b0, 32'h1, 32'h1, 16'h1, 32'h0,
                     32'h5A5A_5A5A, 1'b1);

        // random phases with different idling
        repeat (210) send_random();
        send_idle_pct = 76;
        recv_idle_pct = 19;
        repeat (210) send_random();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (210) send_random();
        req_if.valid <= 1'b0;

        // drain
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[integer_execute_alu] OK");
        end else begin
            $display("[integer_execute_alu] ERROR");
        end
        $finish;
    end
endmodule
